/* src/edfts_pkg.sv */
// Shared widths, request codes and controller/datapath interface types for the EDF scheduler.
package edfts_pkg;

   localparam int MAX_ENTRIES_DEF = 16;

   localparam int TIME_W = 32;
   localparam int VAL_W  = 16;
   localparam int NUM_W  = 5;
   localparam int TYPE_W = 2;
   localparam int IDX_IN_W = 4;

   localparam logic [TYPE_W-1:0] REQ_TICK    = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_LOAD    = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_RESTART = 2'd2;

   typedef struct packed {
      logic capture;
      logic scan_start;
      logic restart;
      logic div_start;
      logic load_write;
      logic finish;
   } edfts_cmd_type;

   typedef struct packed {
      logic scan_busy;
      logic div_busy;
      logic load_ok;
      logic out_free;
   } edfts_sts_type;

endpackage

/* src/edf_tick_scheduler_unit.sv */
// Top level of the earliest-deadline-first tick scheduler.
// A tick word scans the active entries one per cycle through the table memories; the
// active entries are the first task_count ones, limited to MAX_ENTRIES. A load word waits
// on the bit-serial remainder unit that places the new entry's release phase at time
// modulo period. Restart and unused words are taken while the block stays idle.
// Exactly one result
// word comes back per tick, held in an output register, so a waiting result only delays the
// following tick's finish. The task_count register is written through the csr port, which
// is always ready; write it only while the block is idle.
module edf_tick_scheduler_unit #(
   parameter int MAX_ENTRIES = edfts_pkg::MAX_ENTRIES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [edfts_pkg::TYPE_W-1:0]    req_type,
   input  logic [edfts_pkg::IDX_IN_W-1:0]  req_task_index,
   input  logic [edfts_pkg::VAL_W-1:0]     req_period_in,
   input  logic [edfts_pkg::VAL_W-1:0]     req_exec_in,
   input  logic [edfts_pkg::VAL_W-1:0]     req_rel_deadline_in,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [edfts_pkg::TIME_W-1:0]    rsp_tick_time,
   output logic                            rsp_busy_res,
   output logic [edfts_pkg::NUM_W-1:0]     rsp_task_number,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [edfts_pkg::NUM_W-1:0]     csr_task_count
);
   import edfts_pkg::*;

   edfts_cmd_type cmd;
   edfts_sts_type sts;

   assign csr_ready = 1'b1;

   edfts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   edfts_dpath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_task_index      (req_task_index),
      .req_period_in       (req_period_in),
      .req_exec_in         (req_exec_in),
      .req_rel_deadline_in (req_rel_deadline_in),
      .csr_valid           (csr_valid),
      .csr_task_count      (csr_task_count),
      .rsp_stall           (rsp_stall),
      .rsp_valid           (rsp_valid),
      .rsp_tick_time       (rsp_tick_time),
      .rsp_busy_res        (rsp_busy_res),
      .rsp_task_number     (rsp_task_number)
   );

endmodule

/* src/edfts_rem.sv */
// Restoring remainder unit: time modulo period, one quotient bit per cycle.
module edfts_rem (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [edfts_pkg::TIME_W-1:0]  dividend,
   input  logic [edfts_pkg::VAL_W-1:0]   divisor,
   output logic                          busy,
   output logic [edfts_pkg::VAL_W-1:0]   remainder
);
   import edfts_pkg::*;

   localparam int CYC_W = $clog2(TIME_W + 1);

   logic [TIME_W-1:0] dvd_ff;
   logic [VAL_W-1:0]  div_ff;
   logic [VAL_W-1:0]  rem_ff;
   logic [CYC_W-1:0]  cnt_ff;
   logic              busy_ff;

   logic [VAL_W:0]    shifted;
   logic [VAL_W-1:0]  rem_in;

   always_comb begin
      shifted = {rem_ff, dvd_ff[TIME_W-1]};
      if (shifted >= {1'b0, div_ff}) begin
         rem_in = VAL_W'(shifted - {1'b0, div_ff});
      end else begin
         rem_in = shifted[VAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CYC_W'(TIME_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CYC_W'(1);
         if (cnt_ff == CYC_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         div_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[TIME_W-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

   assign busy      = busy_ff;
   assign remainder = rem_ff;

endmodule

/* src/edfts_dpath.sv */
// Datapath: task table memories, per-entry scan pipeline, time counter and result register.
module edfts_dpath #(
   parameter int MAX_ENTRIES = edfts_pkg::MAX_ENTRIES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  edfts_pkg::edfts_cmd_type        cmd,
   output edfts_pkg::edfts_sts_type        sts,
   input  logic [edfts_pkg::IDX_IN_W-1:0]  req_task_index,
   input  logic [edfts_pkg::VAL_W-1:0]     req_period_in,
   input  logic [edfts_pkg::VAL_W-1:0]     req_exec_in,
   input  logic [edfts_pkg::VAL_W-1:0]     req_rel_deadline_in,
   input  logic                            csr_valid,
   input  logic [edfts_pkg::NUM_W-1:0]     csr_task_count,
   input  logic                            rsp_stall,
   output logic                            rsp_valid,
   output logic [edfts_pkg::TIME_W-1:0]    rsp_tick_time,
   output logic                            rsp_busy_res,
   output logic [edfts_pkg::NUM_W-1:0]     rsp_task_number
);
   import edfts_pkg::*;

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   // Configuration and captured request word
   logic [NUM_W-1:0]    task_count_ff;
   logic [TIME_W-1:0]   time_ff;
   logic [IDX_IN_W-1:0] cap_idx_ff;
   logic [VAL_W-1:0]    cap_per_ff;
   logic [VAL_W-1:0]    cap_exec_ff;
   logic [VAL_W-1:0]    cap_rel_ff;

   // Task table
   logic [VAL_W-1:0]  period_mem [MAX_ENTRIES];
   logic [VAL_W-1:0]  exec_mem   [MAX_ENTRIES];
   logic [VAL_W-1:0]  rel_mem    [MAX_ENTRIES];
   logic [VAL_W-1:0]  bud_mem    [MAX_ENTRIES];
   logic [TIME_W-1:0] dl_mem     [MAX_ENTRIES];
   logic [VAL_W-1:0]  phase_mem  [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] bud_vld_ff;
   logic [MAX_ENTRIES-1:0] phase_vld_ff;

   // Registered read data
   logic [VAL_W-1:0]  rd_per_ff;
   logic [VAL_W-1:0]  rd_exec_ff;
   logic [VAL_W-1:0]  rd_rel_ff;
   logic [VAL_W-1:0]  rd_bud_ff;
   logic [TIME_W-1:0] rd_dl_ff;
   logic [VAL_W-1:0]  rd_phase_ff;
   logic              rd_bud_vld_ff;
   logic              rd_phase_vld_ff;

   // Scan pipeline
   logic [CNT_W-1:0]  issue_ff;
   logic              issuing_ff;
   logic              proc_vld_ff;
   logic [IDX_W-1:0]  proc_idx_ff;
   logic              best_found_ff;
   logic [IDX_W-1:0]  best_idx_ff;
   logic [TIME_W-1:0] best_dl_ff;
   logic [VAL_W-1:0]  best_bud_ff;

   // Result register
   logic              rsp_valid_ff;
   logic [TIME_W-1:0] rsp_time_ff;
   logic              rsp_busy_ff;
   logic [NUM_W-1:0]  rsp_num_ff;

   logic [CNT_W-1:0]  n_active;
   logic [IDX_W-1:0]  issue_addr;
   logic              last_issue;
   logic [7:0]        idx_ext;
   logic [IDX_W-1:0]  load_addr;
   logic [VAL_W-1:0]  load_phase;

   logic [VAL_W-1:0]  cur_phase;
   logic              released;
   logic [VAL_W-1:0]  cur_bud;
   logic [TIME_W-1:0] cur_dl;
   logic              take;
   logic [VAL_W:0]    phase_inc;
   logic [VAL_W-1:0]  next_phase;

   logic              bud_we;
   logic [IDX_W-1:0]  bud_waddr;
   logic [VAL_W-1:0]  bud_wdata;
   logic              phase_we;
   logic [IDX_W-1:0]  phase_waddr;
   logic [VAL_W-1:0]  phase_wdata;

   logic              div_busy;
   logic [VAL_W-1:0]  div_rem;
   logic [7:0]        num_sum;

   edfts_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (time_ff),
      .divisor   (cap_per_ff),
      .busy      (div_busy),
      .remainder (div_rem)
   );

   always_comb begin
      if (8'(task_count_ff) > 8'(MAX_ENTRIES)) begin
         n_active = CNT_W'(MAX_ENTRIES);
      end else begin
         n_active = CNT_W'(task_count_ff);
      end
   end

   assign issue_addr = issue_ff[IDX_W-1:0];
   assign last_issue = (issue_ff + CNT_W'(1)) == n_active;
   assign idx_ext    = 8'(cap_idx_ff);
   assign load_addr  = idx_ext[IDX_W-1:0];
   assign load_phase = (cap_per_ff == '0) ? '0 : div_rem;

   // Release, candidate compare and phase advance for the entry in the process stage.
   always_comb begin
      cur_phase = rd_phase_vld_ff ? rd_phase_ff : '0;
      released  = (cur_phase == '0);
      if (released) begin
         cur_bud = rd_exec_ff;
         cur_dl  = time_ff + TIME_W'(rd_rel_ff);
      end else begin
         cur_bud = rd_bud_vld_ff ? rd_bud_ff : '0;
         cur_dl  = rd_dl_ff;
      end
      take       = (cur_bud != '0) && (!best_found_ff || (cur_dl < best_dl_ff));
      phase_inc  = {1'b0, cur_phase} + (VAL_W+1)'(1);
      next_phase = (phase_inc >= {1'b0, rd_per_ff}) ? '0 : phase_inc[VAL_W-1:0];
   end

   always_comb begin
      if (cmd.finish) begin
         bud_we    = best_found_ff;
         bud_waddr = best_idx_ff;
         bud_wdata = best_bud_ff - VAL_W'(1);
      end else begin
         bud_we    = proc_vld_ff;
         bud_waddr = proc_idx_ff;
         bud_wdata = cur_bud;
      end
      if (cmd.load_write) begin
         phase_we    = 1'b1;
         phase_waddr = load_addr;
         phase_wdata = load_phase;
      end else begin
         phase_we    = proc_vld_ff;
         phase_waddr = proc_idx_ff;
         phase_wdata = next_phase;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_write) begin
         period_mem[load_addr] <= cap_per_ff;
         exec_mem[load_addr]   <= cap_exec_ff;
         rel_mem[load_addr]    <= cap_rel_ff;
      end
      rd_per_ff  <= period_mem[issue_addr];
      rd_exec_ff <= exec_mem[issue_addr];
      rd_rel_ff  <= rel_mem[issue_addr];
   end

   always_ff @(posedge clock) begin
      if (bud_we) begin
         bud_mem[bud_waddr] <= bud_wdata;
      end
      rd_bud_ff <= bud_mem[issue_addr];
   end

   // A loaded entry keeps a stale deadline, which is never selected before its next release, as its budget reads zero.
   always_ff @(posedge clock) begin
      if (proc_vld_ff) begin
         dl_mem[proc_idx_ff] <= cur_dl;
      end
      rd_dl_ff <= dl_mem[issue_addr];
   end

   always_ff @(posedge clock) begin
      if (phase_we) begin
         phase_mem[phase_waddr] <= phase_wdata;
      end
      rd_phase_ff <= phase_mem[issue_addr];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.restart) begin
         bud_vld_ff   <= '0;
         phase_vld_ff <= '0;
      end else begin
         if (bud_we) begin
            bud_vld_ff[bud_waddr] <= 1'b1;
         end
         if (phase_we) begin
            phase_vld_ff[phase_waddr] <= 1'b1;
         end
         if (cmd.load_write) begin
            bud_vld_ff[load_addr] <= 1'b0;
         end
      end
      rd_bud_vld_ff   <= bud_vld_ff[issue_addr];
      rd_phase_vld_ff <= phase_vld_ff[issue_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         task_count_ff <= '0;
         time_ff       <= '0;
      end else begin
         if (csr_valid) begin
            task_count_ff <= csr_task_count;
         end
         if (cmd.restart) begin
            time_ff <= '0;
         end else if (cmd.finish) begin
            time_ff <= time_ff + TIME_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cap_idx_ff  <= req_task_index;
         cap_per_ff  <= req_period_in;
         cap_exec_ff <= req_exec_in;
         cap_rel_ff  <= req_rel_deadline_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issuing_ff  <= 1'b0;
         proc_vld_ff <= 1'b0;
         issue_ff    <= '0;
      end else if (cmd.scan_start) begin
         issuing_ff  <= (n_active != '0);
         proc_vld_ff <= 1'b0;
         issue_ff    <= '0;
      end else begin
         proc_vld_ff <= issuing_ff;
         if (issuing_ff) begin
            issue_ff <= issue_ff + CNT_W'(1);
            if (last_issue) begin
               issuing_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      proc_idx_ff <= issue_addr;
      if (cmd.scan_start) begin
         best_found_ff <= 1'b0;
      end else if (proc_vld_ff && take) begin
         best_found_ff <= 1'b1;
         best_idx_ff   <= proc_idx_ff;
         best_dl_ff    <= cur_dl;
         best_bud_ff   <= cur_bud;
      end
   end

   assign num_sum = 8'(best_idx_ff) + 8'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.finish) begin
         rsp_time_ff <= time_ff;
         rsp_busy_ff <= best_found_ff;
         rsp_num_ff  <= best_found_ff ? num_sum[NUM_W-1:0] : '0;
      end
   end

   assign sts.scan_busy = issuing_ff || proc_vld_ff;
   assign sts.div_busy  = div_busy;
   assign sts.load_ok   = idx_ext < 8'(MAX_ENTRIES);
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tick_time   = rsp_time_ff;
   assign rsp_busy_res    = rsp_busy_ff;
   assign rsp_task_number = rsp_num_ff;

   a_finish_room: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result loaded over a word still waiting");

   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finished tick did not raise the result");

   a_idle_number: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_busy_ff) |-> (rsp_num_ff == '0))
      else $error("idle tick carries a task number");

   a_scan_div: assert property (@(posedge clock) disable iff (reset)
      (issuing_ff || proc_vld_ff) |-> !div_busy)
      else $error("scan overlaps the remainder unit");

endmodule

/* src/edfts_ctrl.sv */
// Controller state machine: request decode, scan, load and result sequencing.
module edfts_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic [edfts_pkg::TYPE_W-1:0]   req_type,
   output logic                           req_stall,
   output edfts_pkg::edfts_cmd_type       cmd,
   input  edfts_pkg::edfts_sts_type       sts
);
   import edfts_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH,
      ST_LOAD_CHK,
      ST_DIV
   } state_type;

   state_type state_ff, state_in;
   logic      req_stall_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               case (req_type)
                  REQ_TICK: begin
                     cmd.scan_start = 1'b1;
                     state_in       = ST_SCAN;
                  end
                  REQ_LOAD: begin
                     state_in = ST_LOAD_CHK;
                  end
                  REQ_RESTART: begin
                     cmd.restart = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (!sts.scan_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_LOAD_CHK: begin
            if (sts.load_ok) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (!sts.div_busy) begin
               cmd.load_write = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_stall_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= (state_in != ST_IDLE);
      end
   end

   assign req_stall = req_stall_ff;

endmodule
